### rtl/core/tod_pkg.sv
// Package for the time-of-day counter: limits, key codes and the state record.
// Used by tod_step and by the top level; depends on nothing.
package tod_pkg;

  localparam logic [5:0] SEC_LIMIT   = 6'd60;
  localparam logic [5:0] MIN_LIMIT   = 6'd60;
  localparam logic [4:0] HOUR_LIMIT  = 5'd24;
  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] START_KEY   = 8'h31;
  localparam logic [3:0] DIGIT_BASE  = 4'd10;

  localparam int unsigned DATA_IN_W  = 8;
  localparam int unsigned DATA_OUT_W = 24;

  // Kind of an input item, carried on tuser.
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_KEY  = 1'b1;

  // Entry phase codes: running, then waiting for digit one to six.
  localparam logic [2:0] PH_RUN    = 3'd0;
  localparam logic [2:0] PH_HOUR_T = 3'd1;
  localparam logic [2:0] PH_HOUR_U = 3'd2;
  localparam logic [2:0] PH_MIN_U  = 3'd4;
  localparam logic [2:0] PH_SEC_U  = 3'd6;

  typedef struct packed {
    logic [4:0] hour_count;
    logic [5:0] minute_count;
    logic [5:0] second_count;
    logic [2:0] phase;
    logic [3:0] held_tens_digit;
  } tod_state_t;

endpackage

### rtl/core/tod_step.sv
// Next-state logic of the time-of-day counter for one tick or key item.
// Depends on tod_pkg for limits, key codes and the state record.
module tod_step import tod_pkg::*; (
  input  tod_state_t  cur,
  input  logic        cmd,
  input  logic [7:0]  key_code,
  output tod_state_t  nxt
);

  logic       entering;
  logic       is_digit;
  logic [7:0] key_off;
  logic [3:0] digit;
  logic [6:0] value;
  logic [6:0] sec_inc;
  logic [6:0] min_inc;
  logic [5:0] hour_inc;

  assign entering = (cur.phase >= PH_HOUR_T) && (cur.phase <= PH_SEC_U);
  assign key_off  = key_code - ASCII_ZERO;
  assign is_digit = (key_code >= ASCII_ZERO) && (key_off < {4'd0, DIGIT_BASE});
  assign digit    = key_off[3:0];
  // tens * 10 + units, at most 99
  assign value    = ({3'd0, cur.held_tens_digit} << 3) + ({3'd0, cur.held_tens_digit} << 1)
                    + {3'd0, digit};
  assign sec_inc  = {1'b0, cur.second_count} + 7'd1;
  assign min_inc  = {1'b0, cur.minute_count} + 7'd1;
  assign hour_inc = {1'b0, cur.hour_count} + 6'd1;

  always_comb begin
    nxt = cur;
    if (cmd == CMD_TICK) begin
      if (!entering) begin
        // advance seconds and ripple the carries
        if (sec_inc >= {1'b0, SEC_LIMIT}) begin
          nxt.second_count = '0;
          if (min_inc >= {1'b0, MIN_LIMIT}) begin
            nxt.minute_count = '0;
            nxt.hour_count   = (hour_inc >= {1'b0, HOUR_LIMIT}) ? '0 : hour_inc[4:0];
          end else begin
            nxt.minute_count = min_inc[5:0];
          end
        end else begin
          nxt.second_count = sec_inc[5:0];
        end
      end
    end else if (!entering) begin
      nxt.phase = (key_code == START_KEY) ? PH_HOUR_T : PH_RUN;
    end else if (is_digit) begin
      if (cur.phase[0]) begin
        // tens digit: hold it until the pair completes
        nxt.held_tens_digit = digit;
        nxt.phase           = cur.phase + 3'd1;
      end else begin
        case (cur.phase)
          PH_HOUR_U: nxt.hour_count   = (value >= {2'd0, HOUR_LIMIT}) ? '0 : value[4:0];
          PH_MIN_U:  nxt.minute_count = (value >= {1'b0, MIN_LIMIT}) ? '0 : value[5:0];
          default:   nxt.second_count = (value >= {1'b0, SEC_LIMIT}) ? '0 : value[5:0];
        endcase
        nxt.phase = (cur.phase >= PH_SEC_U) ? PH_RUN : cur.phase + 3'd1;
      end
    end
  end

endmodule

### rtl/core/time_of_day_counter_with_key_set.sv
// Top level of the 24-hour time-of-day counter with keypad time setting.
// Depends on tod_pkg and tod_step.
//
//  channel  | dir | tdata (low bit up)                              | tuser
//  s_axis   | in  | key_code[7:0]                                   | cmd (0 tick, 1 key)
//  m_axis   | out | hours[4:0] minutes[10:5] seconds[16:11]         | -
//           |     | entry_phase[19:17], zero [23:20]                |
//
// One item per cycle unless the sink stalls; each item gives one result, in the cycle after it is accepted.
// The time registers are updated in the accept cycle by tod_step; the result
// register holds the state after the item until the sink takes it.
// s_axis_tready is high while the result register is empty or being drained.
// Reset clears the time to 00:00:00, running, and empties the result register.
module time_of_day_counter_with_key_set import tod_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [DATA_IN_W-1:0]  s_axis_tdata,   // key_code[7:0]
  input  logic                  s_axis_tuser,   // cmd
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [DATA_OUT_W-1:0] m_axis_tdata    // hours, minutes, seconds, entry_phase, pad
);

  tod_state_t state;
  tod_state_t state_next;
  logic       in_fire;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  tod_step u_step (
    .cur      (state),
    .cmd      (s_axis_tuser),
    .key_code (s_axis_tdata),
    .nxt      (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (in_fire) begin
        state         <= state_next;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  assign m_axis_tdata = {4'd0, state.phase, state.second_count, state.minute_count,
                         state.hour_count};

endmodule

### rtl/core/tod_checker.sv
// Port-level checks for the time-of-day counter, bound to the top level.
// Depends on tod_pkg for the time limits.
module tod_checker import tod_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [DATA_OUT_W-1:0] m_axis_tdata
);

  // an empty result register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty result register");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[4:0] < HOUR_LIMIT) && (m_axis_tdata[10:5] < MIN_LIMIT)
                      && (m_axis_tdata[16:11] < SEC_LIMIT))
    else $error("time field out of range");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[19:17] <= PH_SEC_U) && (m_axis_tdata[23:20] == 4'd0))
    else $error("bad entry phase or padding");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind time_of_day_counter_with_key_set tod_checker u_tod_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
